@@ rtl/crs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the calibration request sequencer: request and result payload
// structs, the sequencer state struct, command bytes and the action, bus,
// operation, phase and event codes. No dependencies.
package crs_pkg;

  // Action codes carried by each request.
  localparam logic [1:0] ACT_RUN   = 2'd0;
  localparam logic [1:0] ACT_LATCH = 2'd1;
  localparam logic [1:0] ACT_TAKE  = 2'd2;

  // Bus status codes.
  localparam logic [1:0] BUS_IDLE = 2'd0;
  localparam logic [1:0] BUS_BUSY = 2'd1;
  localparam logic [1:0] BUS_OK   = 2'd2;

  // Operation codes.
  localparam logic OP_CAL   = 1'b0;
  localparam logic OP_ERASE = 1'b1;

  // Repeated command bytes.
  localparam logic [7:0] CAL_VALUE   = 8'haa;
  localparam logic [7:0] ERASE_VALUE = 8'hbb;

  // Lifecycle event codes.
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_DISCONNECT  = 3'd1;
  localparam logic [2:0] EV_UNSUPPORTED = 3'd2;
  localparam logic [2:0] EV_STARTED     = 3'd3;
  localparam logic [2:0] EV_COMPLETED   = 3'd4;
  localparam logic [2:0] EV_ERASED      = 3'd5;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_POLL_READY = 2'd1,
    PH_WRITE      = 2'd2,
    PH_POLL_RESP  = 2'd3
  } crs_phase_t;

  // One incoming request.
  typedef struct packed {
    logic [1:0] action;
    logic       operation;
    logic [7:0] attached_mode;
    logic       accessory_valid;
    logic [1:0] link_status;
    logic       bus_accepts;
    logic [7:0] read_low_byte;
    logic [7:0] read_high_byte;
  } crs_in_t;

  // One result.
  typedef struct packed {
    logic       start_write;
    logic       start_read;
    logic [7:0] write_low_byte;
    logic [7:0] write_high_byte;
    logic [2:0] taken_event;
    logic       pending;
    logic       active;
    logic       owns_bus;
  } crs_out_t;

  // Architectural state of the sequencer.
  typedef struct packed {
    logic [1:0] pending_requests;
    logic       current_operation;
    crs_phase_t phase;
    logic [7:0] exch_lo;
    logic [7:0] exch_hi;
    logic [2:0] held_event;
    logic       in_flight;
  } crs_state_t;

endpackage

@@ rtl/crs_in_reg.sv @@
`timescale 1ns / 1ps
// Input register stage for the calibration request sequencer.
// Depends on crs_pkg for the request payload struct.
module crs_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  crs_pkg::crs_in_t in_data,
  output logic             req_valid,
  input  logic             req_take,
  output crs_pkg::crs_in_t req_data
);

  logic             valid_r;
  logic             valid_nxt;
  crs_pkg::crs_in_t data_r;

  // The stage can load whenever it is empty or its request moves on this cycle.
  assign in_ready  = !valid_r || req_take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (req_take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign req_valid = valid_r;
  assign req_data  = data_r;

endmodule

@@ rtl/crs_step.sv @@
`timescale 1ns / 1ps
// Combinational step logic: next sequencer state and result for one request.
// Depends on crs_pkg for the payload, state and code definitions.
module crs_step (
  input  crs_pkg::crs_in_t    req,
  input  crs_pkg::crs_state_t state_i,
  input  logic [7:0]          required_mode,
  output crs_pkg::crs_state_t state_o,
  output crs_pkg::crs_out_t   result
);

  always_comb begin
    crs_pkg::crs_state_t s;
    crs_pkg::crs_out_t   r;
    logic                run;
    logic [1:0]          bus;
    logic [7:0]          cmd;

    s   = state_i;
    r   = '0;
    run = 1'b1;
    bus = req.link_status;
    cmd = crs_pkg::CAL_VALUE;

    case (req.action)
      // Latch a request as a pending bit.
      crs_pkg::ACT_LATCH: begin
        if (req.operation == crs_pkg::OP_ERASE) begin
          s.pending_requests[1] = 1'b1;
        end else begin
          s.pending_requests[0] = 1'b1;
        end
      end

      // Hand out the held event and clear it.
      crs_pkg::ACT_TAKE: begin
        r.taken_event = s.held_event;
        s.held_event  = crs_pkg::EV_NONE;
      end

      crs_pkg::ACT_RUN: begin
        // Retire a finished transfer; an idle or failed status counts as a failure.
        if (s.in_flight) begin
          if (bus == crs_pkg::BUS_BUSY) begin
            run = 1'b0;
          end else begin
            s.in_flight = 1'b0;
            if (bus == crs_pkg::BUS_OK) begin
              case (s.phase)
                crs_pkg::PH_POLL_READY: begin
                  s.exch_lo = req.read_low_byte;
                  s.exch_hi = req.read_high_byte;
                  if (s.exch_lo == 8'd0 && s.exch_hi == 8'd0) begin
                    cmd = (s.current_operation == crs_pkg::OP_ERASE) ?
                          crs_pkg::ERASE_VALUE : crs_pkg::CAL_VALUE;
                    s.exch_lo = cmd;
                    s.exch_hi = cmd;
                    s.phase   = crs_pkg::PH_WRITE;
                    if (s.current_operation == crs_pkg::OP_CAL) begin
                      s.held_event = crs_pkg::EV_STARTED;
                    end
                  end
                end
                crs_pkg::PH_WRITE: begin
                  s.exch_lo = 8'd0;
                  s.exch_hi = 8'd0;
                  s.phase   = crs_pkg::PH_POLL_RESP;
                end
                crs_pkg::PH_POLL_RESP: begin
                  s.exch_lo = req.read_low_byte;
                  s.exch_hi = req.read_high_byte;
                  if (s.exch_lo == 8'd0 && s.exch_hi == 8'd0) begin
                    if (s.current_operation == crs_pkg::OP_ERASE) begin
                      s.pending_requests[1] = 1'b0;
                      s.held_event          = crs_pkg::EV_ERASED;
                    end else begin
                      s.pending_requests[0] = 1'b0;
                      s.held_event          = crs_pkg::EV_COMPLETED;
                    end
                    s.phase = crs_pkg::PH_IDLE;
                  end
                end
                default: begin
                  s.exch_lo = req.read_low_byte;
                  s.exch_hi = req.read_high_byte;
                end
              endcase
            end
            bus = crs_pkg::BUS_IDLE;
          end
        end

        if (run) begin
          // Pick a pending request, calibrate first; at most two attempts.
          for (int i = 0; i < 2; i++) begin
            if (s.phase == crs_pkg::PH_IDLE && s.pending_requests != 2'd0) begin
              s.current_operation = s.pending_requests[0] ? crs_pkg::OP_CAL :
                                                            crs_pkg::OP_ERASE;
              if (s.current_operation == crs_pkg::OP_CAL &&
                  req.attached_mode != required_mode) begin
                s.held_event          = crs_pkg::EV_DISCONNECT;
                s.pending_requests[0] = 1'b0;
              end else if (!req.accessory_valid) begin
                s.held_event = crs_pkg::EV_UNSUPPORTED;
                if (s.current_operation == crs_pkg::OP_ERASE) begin
                  s.pending_requests[1] = 1'b0;
                end else begin
                  s.pending_requests[0] = 1'b0;
                end
              end else begin
                s.exch_lo = 8'd0;
                s.exch_hi = 8'd0;
                s.phase   = crs_pkg::PH_POLL_READY;
              end
            end
          end

          // Start the next transfer when the bus is free.
          if (bus == crs_pkg::BUS_IDLE && s.phase != crs_pkg::PH_IDLE) begin
            s.in_flight = req.bus_accepts;
            if (req.bus_accepts) begin
              if (s.phase == crs_pkg::PH_WRITE) begin
                r.start_write     = 1'b1;
                r.write_low_byte  = s.exch_lo;
                r.write_high_byte = s.exch_hi;
              end else begin
                r.start_read = 1'b1;
              end
            end
          end
        end
      end

      default: begin
      end
    endcase

    // Status reflects the state after this step.
    r.pending  = (s.pending_requests != 2'd0) || (s.phase != crs_pkg::PH_IDLE) ||
                 s.in_flight;
    r.active   = (s.phase == crs_pkg::PH_WRITE) || (s.phase == crs_pkg::PH_POLL_RESP);
    r.owns_bus = s.in_flight;

    state_o = s;
    result  = r;
  end

endmodule

@@ rtl/calibration_request_sequencer_top.sv @@
`timescale 1ns / 1ps
// Top level of the calibration request sequencer: state, configuration and
// result registers. Depends on crs_pkg, crs_in_reg and crs_step.
//
// Usage:
//   Requests enter on in_valid/in_ready with an in_data struct; each request
//   is a run step, a request latch or an event take. Every request yields
//   exactly one result on out_valid/out_ready with an out_data struct.
//   cfg_wr_en/cfg_wr_data write the required wheel mode with no wait; write it
//   only while no request is in progress.
//   A request in the input register is stepped into the result register when
//   the result register is free or being drained. Throughput: one request
//   per cycle while the receiver does not stall, set by the combinational
//   step logic between the input and result registers.
//   When the receiver stalls, the result stays in the output register and
//   the input register still takes one more request; after that in_ready
//   drops until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers, clears pending
//   requests, phase, exchange bytes, held event and the required wheel mode.
module calibration_request_sequencer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crs_pkg::crs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output crs_pkg::crs_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  logic                req_valid;
  logic                req_take;
  crs_pkg::crs_in_t    req_data;
  crs_pkg::crs_state_t state_r;
  crs_pkg::crs_state_t state_nxt;
  crs_pkg::crs_out_t   result;
  crs_pkg::crs_out_t   out_data_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [7:0]          req_mode_cfg_r;

  crs_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .req_valid (req_valid),
    .req_take  (req_take),
    .req_data  (req_data)
  );

  crs_step u_step (
    .req           (req_data),
    .state_i       (state_r),
    .required_mode (req_mode_cfg_r),
    .state_o       (state_nxt),
    .result        (result)
  );

  // A request is processed when the result register is free or being drained.
  assign req_take      = req_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = req_take ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_mode_cfg_r <= 8'd0;
    end else if (cfg_wr_en) begin
      req_mode_cfg_r <= cfg_wr_data;
    end
  end

  // Sequencer state advances once per processed request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{pending_requests:  2'd0,
                   current_operation: crs_pkg::OP_CAL,
                   phase:             crs_pkg::PH_IDLE,
                   exch_lo:           8'd0,
                   exch_hi:           8'd0,
                   held_event:        crs_pkg::EV_NONE,
                   in_flight:         1'b0};
    end else if (req_take) begin
      state_r <= state_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (req_take) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
